@@ src/sof_length_xor_frame_receiver_macros.svh @@
// Assertion macros for the frame receiver.
`ifndef SOF_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH
`define SOF_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH

// Clocked check, off during reset.
`define SOFX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check, also active during reset.
`define SOFX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/sofx_pkg.sv @@
// Shared types and constants of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package sofx_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 60;

    localparam logic [7:0] START_A = 8'hFD;
    localparam logic [7:0] START_B = 8'hFE;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_CODE = 1'd1;

    localparam logic [7:0] ALIVE_CODE_RST = 8'h00;
    localparam logic [7:0] REPLY_CODE_RST = 8'h01;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_CMD  = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

endpackage
`default_nettype wire

@@ src/sof_length_xor_frame_receiver.sv @@
// Start byte / length / XOR check frame receiver, top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sof_length_xor_frame_receiver_macros.svh"
// Takes one stream byte per cycle and hunts for a 0xFD or 0xFE start byte; a
// frame is start, length, command, payload, then an XOR check of length,
// command and payload. Reception runs at one byte per cycle when not stalled.
// A good frame starts an emit run from the payload store: a keep-alive run is
// 4 bytes, a forwarded run is length + 1 bytes, and while it drains the input
// is stalled (one output byte per cycle while the output side does not stall).
// The store has one write port and one registered read port, which sets the
// drain at one byte per cycle. Bad frames and over-long lengths are dropped
// without output.
module sof_length_xor_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = sofx_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_kind,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [sofx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sofx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sofx_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned SEQ_W = (CNT_W > 1) ? CNT_W : 2;

    logic [7:0]       r_alive_code;
    logic [7:0]       r_reply_code;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_start, n_start;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_cmd, n_cmd;

    logic             r_busy, n_busy;
    logic             r_seq_fwd, n_seq_fwd;
    logic [SEQ_W-1:0] r_seq_idx, n_seq_idx;
    logic [IDX_W-1:0] r_ptr, n_ptr;

    logic [7:0]       r_mem [MAX_PAYLOAD];
    logic [7:0]       r_mem_q;

    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_last, n_last;

    logic             w_in_acc;
    logic             w_body_data;
    logic             w_frame_end;
    logic             w_good;
    logic             w_wr;
    logic             w_emit;
    logic             w_item_last;
    logic [7:0]       w_item_byte;

    assign o_in_stall = r_busy;
    assign w_in_acc   = i_in_valid && !r_busy;

    assign w_body_data = (r_count < r_len) && (r_count < CNT_W'(MAX_PAYLOAD));
    assign w_frame_end = w_in_acc && (r_phase == PH_BODY) && !w_body_data;
    assign w_good      = w_frame_end && (i_rx_byte == r_xor);
    assign w_wr        = w_in_acc && (r_phase == PH_BODY) && w_body_data;
    assign w_emit      = r_busy && (!r_out_valid || !i_out_stall);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive_code <= ALIVE_CODE_RST;
            r_reply_code <= REPLY_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALIVE_CODE: r_alive_code <= i_cfg_data[7:0];
                CFG_REPLY_CODE: r_reply_code <= i_cfg_data[7:0];
            endcase
        end
    end

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (w_in_acc) begin
            unique case (r_phase)
                PH_HUNT: if (i_rx_byte == START_A || i_rx_byte == START_B) n_phase = PH_LEN;
                PH_LEN:  n_phase = (i_rx_byte > 8'(MAX_PAYLOAD)) ? PH_HUNT : PH_CMD;
                PH_CMD:  n_phase = PH_BODY;
                PH_BODY: if (!w_body_data) n_phase = PH_HUNT;
            endcase
        end
    end

    // frame datapath
    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_count = r_count;
        n_xor   = r_xor;
        n_cmd   = r_cmd;
        if (w_in_acc) begin
            unique case (r_phase)
                PH_HUNT: if (i_rx_byte == START_A || i_rx_byte == START_B) n_start = i_rx_byte;
                PH_LEN: begin
                    if (i_rx_byte <= 8'(MAX_PAYLOAD)) begin
                        n_len   = i_rx_byte[CNT_W-1:0];
                        n_xor   = i_rx_byte;
                        n_count = '0;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = '0;
                end
                PH_BODY: begin
                    if (w_body_data) begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_count = r_count + 1'b1;
                    end
                end
            endcase
        end
    end

    // emit sequencer item selection
    always_comb begin
        if (r_seq_fwd) begin
            if (r_seq_idx == '0) begin
                w_item_byte = r_cmd;
                w_item_last = (r_len == '0);
            end else begin
                w_item_byte = r_mem_q;
                w_item_last = (r_seq_idx == SEQ_W'(r_len));
            end
        end else begin
            case (r_seq_idx[1:0])
                2'd0:    w_item_byte = r_start;
                2'd1:    w_item_byte = 8'h00;
                default: w_item_byte = r_reply_code;
            endcase
            w_item_last = (r_seq_idx[1:0] == 2'd3);
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_seq_fwd = r_seq_fwd;
        n_seq_idx = r_seq_idx;
        n_ptr     = r_ptr;
        if (w_good) begin
            n_busy    = 1'b1;
            n_seq_fwd = (r_cmd != r_alive_code);
            n_seq_idx = '0;
            n_ptr     = '0;
        end else if (w_emit) begin
            if (w_item_last) begin
                n_busy = 1'b0;
            end else begin
                n_seq_idx = r_seq_idx + 1'b1;
                if (r_seq_fwd) n_ptr = r_seq_idx[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_kind      = !r_seq_fwd;
            n_out_byte  = w_item_byte;
            n_last      = w_item_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_start     <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_xor       <= '0;
            r_cmd       <= '0;
            r_busy      <= 1'b0;
            r_seq_fwd   <= 1'b0;
            r_seq_idx   <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_len       <= n_len;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_cmd       <= n_cmd;
            r_busy      <= n_busy;
            r_seq_fwd   <= n_seq_fwd;
            r_seq_idx   <= n_seq_idx;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_count[IDX_W-1:0]] <= i_rx_byte;
        r_mem_q <= r_mem[n_ptr];
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

    `SOFX_ASSERT(a_ptr_tracks_seq, r_busy && r_seq_fwd && r_seq_idx != '0 |-> SEQ_W'(r_ptr) == r_seq_idx - 1'b1, "store pointer out of step with emit index")
    `SOFX_ASSERT(a_count_le_len, r_phase == PH_BODY |-> r_count <= r_len, "payload count past frame length")
    `SOFX_ASSERT(a_alive_run_len, r_busy && !r_seq_fwd |-> r_seq_idx <= SEQ_W'(3), "keep-alive reply longer than four bytes")
    `SOFX_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_busy && !r_out_valid, "reset left a run pending")

endmodule
`default_nettype wire

@@ tb/sof_length_xor_frame_checker.sv @@
// Checker for the frame receiver: tracks the byte stream, predicts each output run, compares.
`timescale 1ns / 1ps
module sof_length_xor_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_kind,
    input  logic [7:0]                      i_out_byte,
    input  logic                            i_last,
    input  logic                            i_cfg_we,
    input  logic [sofx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sofx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending,
    output logic                            o_hunting
);
    import sofx_pkg::*;

    localparam int unsigned PAYLOAD_MAX = MAX_PAYLOAD_DEF;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_out_byte;

    t_out_byte  out_due_q[$];
    int         mismatch_count = 0;
    logic [7:0] alive_code_r;
    logic [7:0] reply_code_r;
    t_phase     ph;
    logic [7:0] start_r;
    logic [7:0] len_r;
    logic [7:0] xsum_r;
    logic [7:0] cmd_r;
    logic [5:0] cnt_r;
    logic [7:0] payload_mem [PAYLOAD_MAX];

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void deframe_byte(input logic [7:0] b);
        int i;
        case (ph)
            PH_HUNT: begin
                if (b == START_A || b == START_B) begin
                    start_r = b;
                    ph = PH_LEN;
                end
            end
            PH_LEN: begin
                // over-long length drops the frame; the length byte is not a start candidate
                if (b > PAYLOAD_MAX) begin
                    ph = PH_HUNT;
                end else begin
                    len_r = b;
                    xsum_r = b;
                    cnt_r = '0;
                    ph = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_r = b;
                xsum_r = xsum_r ^ b;
                cnt_r = '0;
                ph = PH_BODY;
            end
            default: begin
                if (cnt_r < len_r && cnt_r < PAYLOAD_MAX) begin
                    payload_mem[cnt_r] = b;
                    xsum_r = xsum_r ^ b;
                    cnt_r = cnt_r + 6'd1;
                end else begin
                    ph = PH_HUNT;
                    if (b == xsum_r) begin
                        if (cmd_r == alive_code_r) begin
                            out_due_q.push_back('{1'b1, start_r, 1'b0});
                            out_due_q.push_back('{1'b1, 8'h00, 1'b0});
                            out_due_q.push_back('{1'b1, reply_code_r, 1'b0});
                            // reply check is 0x00 ^ reply code
                            out_due_q.push_back('{1'b1, reply_code_r, 1'b1});
                        end else begin
                            out_due_q.push_back('{1'b0, cmd_r, len_r == 8'd0});
                            for (i = 0; i < int'(len_r); i++) begin
                                out_due_q.push_back('{1'b0, payload_mem[i],
                                                      i + 1 == int'(len_r)});
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_byte due;
        if (!i_rst_n) begin
            alive_code_r = ALIVE_CODE_RST;
            reply_code_r = REPLY_CODE_RST;
            ph = PH_HUNT;
            start_r = '0;
            len_r = '0;
            xsum_r = '0;
            cmd_r = '0;
            cnt_r = '0;
            out_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ALIVE_CODE) begin
                    alive_code_r = i_cfg_data;
                end else if (i_cfg_idx == CFG_REPLY_CODE) begin
                    reply_code_r = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (out_due_q.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing due", i_out_byte));
                end else begin
                    due = out_due_q.pop_front();
                    if (i_kind !== due.kind) begin
                        report_mismatch($sformatf("kind %0b, want %0b", i_kind, due.kind));
                    end
                    if (i_out_byte !== due.value) begin
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  i_out_byte, due.value));
                    end
                    if (i_last !== due.last) begin
                        report_mismatch($sformatf("last %0b, want %0b", i_last, due.last));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_pending <= out_due_q.size();
        o_hunting <= (ph == PH_HUNT);
    end

endmodule

@@ tb/tb_sof_length_xor_frame_receiver.sv @@
// Testbench top for the frame receiver: clock, reset, byte stream stimulus and verdict.
`timescale 1ns / 1ps
module tb_sof_length_xor_frame_receiver;
    import sofx_pkg::*;

    localparam int unsigned PAYLOAD_MAX = MAX_PAYLOAD_DEF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic [7:0]            out_byte;
    logic                  last;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_ALIVE_CODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int         mismatches;
    int         pending;
    logic       hunting;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         bytes_sent = 0;
    logic [7:0] alive_now = ALIVE_CODE_RST;

    sof_length_xor_frame_receiver #(
        .MAX_PAYLOAD(PAYLOAD_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_rx_byte   (rx_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_kind      (kind),
        .o_out_byte  (out_byte),
        .o_last      (last),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    sof_length_xor_frame_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_kind       (kind),
        .i_out_byte   (out_byte),
        .i_last       (last),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_hunting    (hunting)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] start, input int len, input logic [7:0] cmd,
                              input bit bad_check);
        logic [7:0] chk;
        logic [7:0] pb;
        int         k;
        chk = len[7:0] ^ cmd;
        send_byte(start);
        send_byte(len[7:0]);
        send_byte(cmd);
        for (k = 0; k < len; k++) begin
            pb = 8'($urandom_range(255));
            chk = chk ^ pb;
            send_byte(pb);
        end
        if (bad_check) chk = chk ^ 8'($urandom_range(255, 1));
        send_byte(chk);
    endtask

    // 0xFF bytes close any open frame: over-long at the length, filler or check in the body
    task automatic flush_to_hunt();
        in_valid <= 1'b0;
        @(posedge clk);
        while (!hunting) begin
            send_byte(8'hFF);
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        flush_to_hunt();
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_codes(input logic [7:0] alive, input logic [7:0] reply);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ALIVE_CODE;
        cfg_data <= alive;
        @(posedge clk);
        cfg_idx  <= CFG_REPLY_CODE;
        cfg_data <= reply;
        @(posedge clk);
        cfg_we   <= 1'b0;
        alive_now = alive;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(6);
        if (r < 95) return $urandom_range(59, 7);
        return PAYLOAD_MAX;
    endfunction

    function automatic logic [7:0] pick_start();
        return $urandom_range(1) ? START_B : START_A;
    endfunction

    task automatic run_random(input int n_bytes);
        int         stop;
        int         r;
        int         k;
        int         nz;
        logic [7:0] b;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            r = $urandom_range(99);
            if (r < 10) begin
                // junk while hunting
                do b = 8'($urandom_range(255)); while (b == START_A || b == START_B);
                send_byte(b);
            end else if (r < 20) begin
                send_byte(pick_start());
                if ($urandom_range(1)) send_byte(8'(PAYLOAD_MAX + 1));
                else send_byte(8'($urandom_range(255, PAYLOAD_MAX + 1)));
            end else if (r < 32) begin
                send_frame(pick_start(), pick_len(), 8'($urandom_range(255)), 1'b1);
            end else if (r < 42) begin
                nz = $urandom_range(6, 1);
                for (k = 0; k < nz; k++) send_byte(8'($urandom_range(255)));
                flush_to_hunt();
            end else if (r < 57) begin
                send_frame(pick_start(), pick_len(), alive_now, 1'b0);
            end else begin
                send_frame(pick_start(), pick_len(), 8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial begin : stim
        logic [7:0] directed_bytes [] = '{
            8'hFD, 8'h00, 8'h00, 8'h00,               // keep-alive, reset codes
            8'hFE, 8'h00, 8'h5A, 8'h5A,               // zero length forward
            8'h00, 8'hFF,                             // junk while hunting
            8'hFE, 8'hFD,                             // over-long length equal to a start
            8'hFD, 8'h01, 8'h33, 8'h80, 8'hB2,        // one payload byte
            8'hFD, 8'h00, 8'h44, 8'h00,               // bad check
            8'hFE, 8'h02, 8'h00, 8'hAA, 8'h55, 8'hFD  // keep-alive with payload
        };
        int         idle_tab [4] = '{0, 59, 0, 32};
        int         stall_tab [4] = '{0, 0, 59, 32};
        logic [7:0] alive_tab [4];
        logic [7:0] reply_tab [4];
        int         p;
        int         k;
        alive_tab = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
        reply_tab = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (k = 0; k < directed_bytes.size(); k++) send_byte(directed_bytes[k]);
        for (p = 0; p < 4; p++) begin
            drain();
            set_codes(alive_tab[p], reply_tab[p]);
            idle_pct  <= idle_tab[p];
            stall_pct <= stall_tab[p];
            if (p == 0) send_frame(pick_start(), PAYLOAD_MAX, ~alive_tab[p], 1'b0);
            run_random(25);
        end
        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
